[sv/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, fixed-point constants and series coefficients for the
// Taylor sine/cosine unit.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int TERM_COUNT_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_TERMS       = 12;

  localparam int MAG_W = 40;  // magnitude of the Q.32 argument
  localparam int S_W   = 36;  // Horner accumulator, signed

  localparam logic [35:0] PI_Q32      = 36'd13493037705;
  localparam logic [35:0] HALF_PI_Q32 = 36'd6746518852;
  localparam logic [35:0] TWO_PI_Q32  = 36'd26986075409;
  localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670178;
  localparam logic [35:0] ONE_Q30     = 36'd1073741824;

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } op_t;

  // Item handed from the front to the back: sign and magnitude of the argument.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } front_item_t;

  // 1/(2i+1)! at Q.32, rounded to nearest.
  function automatic logic [32:0] inv_odd_fact(input logic [3:0] idx);
    logic [32:0] c;
    unique case (idx)
      4'd0:    c = 33'd4294967296;
      4'd1:    c = 33'd715827883;
      4'd2:    c = 33'd35791394;
      4'd3:    c = 33'd852176;
      4'd4:    c = 33'd11836;
      4'd5:    c = 33'd108;
      4'd6:    c = 33'd1;
      default: c = 33'd0;
    endcase
    return c;
  endfunction

  // Alternating-sign coefficient: odd indexes are negative.
  function automatic logic signed [S_W-1:0] coef_signed(input logic [3:0] idx);
    logic signed [S_W-1:0] c;
    c = $signed({3'b000, inv_odd_fact(idx)});
    return idx[0] ? -c : c;
  endfunction

endpackage

[sv/tsc_front.sv]
// ----------------------------------------------------------------------------
// tsc_front
// Input stage: forms the Q.32 argument, turns cosine into a shifted sine and
// splits the argument into sign and magnitude.
// ----------------------------------------------------------------------------
module tsc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic signed [31:0]  angle,
  output logic                push,
  input  logic                q_full,
  output tsc_pkg::front_item_t item
);

  logic                 f_valid_r, f_valid_nxt;
  tsc_pkg::front_item_t item_r;
  logic signed [40:0]   arg;
  logic                 take;

  always_comb begin
    arg = {angle[31], angle, 8'd0};
    if (op == tsc_pkg::OP_COSINE) begin
      arg = $signed({5'd0, tsc_pkg::HALF_PI_Q32}) - arg;
    end
  end

  assign push     = f_valid_r && !q_full;
  assign in_ready = !f_valid_r || !q_full;
  assign take     = in_valid && in_ready;
  assign item     = item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (push) f_valid_nxt = 1'b0;
    if (take) f_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.neg <= arg[40];
      item_r.mag <= arg[40] ? 40'(-arg) : arg[39:0];
    end
  end

endmodule

[sv/tsc_queue.sv]
// ----------------------------------------------------------------------------
// tsc_queue
// Short FIFO between front and back with a registered read port.
// ----------------------------------------------------------------------------
module tsc_queue #(
  parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tsc_pkg::front_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output logic                 rd_valid,
  output tsc_pkg::front_item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tsc_pkg::front_item_t mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          rd_valid_r;
  tsc_pkg::front_item_t rd_item_r;
  logic          pop;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign pop      = rd_en && (count_r != '0);
  assign rd_valid = rd_valid_r;
  assign rd_item  = rd_item_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (rd_en) rd_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_item;
    if (pop)  rd_item_r     <= mem[rd_ptr_r];
  end

endmodule

[sv/tsc_back.sv]
// ----------------------------------------------------------------------------
// tsc_back
// Evaluation pipeline: range reduction, quadrant fold, Horner series,
// final scaling and saturation. All stages advance together.
// ----------------------------------------------------------------------------
module tsc_back #(
  parameter int TERM_COUNT = tsc_pkg::TERM_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_valid,
  input  tsc_pkg::front_item_t rd_item,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_value
);

  localparam int NSTEP = TERM_COUNT - 1;
  localparam int SW    = tsc_pkg::S_W;

  // reduction stages
  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic        n1_r, n2_r, n3_r, n4_r;
  logic [39:0] m1_r;
  logic [5:0]  k1_r;
  logic [35:0] r2_r;
  logic [33:0] r3_r;
  logic [31:0] x4_r;

  logic [61:0] kprod;
  logic [41:0] prod2;
  logic [41:0] prod2c;
  logic [35:0] r3a;
  logic [35:0] r3b;
  logic        n3b;
  logic [33:0] r4a;
  logic [33:0] r4sum;
  logic [63:0] xsq;

  // Horner stages
  logic                 hv_r  [0:NSTEP];
  logic signed [SW-1:0] hs_r  [0:NSTEP];
  logic [32:0]          hx2_r [0:NSTEP];
  logic [31:0]          hx_r  [0:NSTEP];
  logic                 hn_r  [0:NSTEP];

  // final stages
  logic        fv_r, fsign_r;
  logic [35:0] fmag_r;
  logic [35:0] smag;
  logic [67:0] fprod;
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [35:0] sat_mag;

  assign advance   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // cycle estimate from the constant reciprocal, a correction each way, then fold
  always_comb begin
    kprod  = rd_item.mag * 62'(tsc_pkg::INV_TWO_PI_Q24);
    prod2  = 42'(k1_r) * 42'(tsc_pkg::TWO_PI_Q32);
    prod2c = (prod2 > 42'(m1_r)) ? prod2 - 42'(tsc_pkg::TWO_PI_Q32) : prod2;
    r3a    = (r2_r >= tsc_pkg::TWO_PI_Q32) ? r2_r - tsc_pkg::TWO_PI_Q32 : r2_r;
    r3b    = r3a;
    n3b    = n2_r;
    if (r3a > tsc_pkg::PI_Q32) begin
      r3b = r3a - tsc_pkg::PI_Q32;
      n3b = !n2_r;
    end
    r4a   = (r3_r > 34'(tsc_pkg::HALF_PI_Q32)) ? 34'(tsc_pkg::PI_Q32) - r3_r : r3_r;
    r4sum = r4a + 34'd2;
    xsq   = 64'(x4_r) * 64'(x4_r) + 64'd536870912;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      k1_r <= kprod[61:56];
      m1_r <= rd_item.mag;
      n1_r <= rd_item.neg;
      r2_r <= 36'(42'(m1_r) - prod2c);
      n2_r <= n1_r;
      r3_r <= r3b[33:0];
      n3_r <= n3b;
      x4_r <= r4sum[33:2];
      n4_r <= n3_r;
      hs_r[0]  <= tsc_pkg::coef_signed(4'(TERM_COUNT - 1));
      hx2_r[0] <= xsq[62:30];
      hx_r[0]  <= x4_r;
      hn_r[0]  <= n4_r;
    end
  end

  assign hv_r[0] = v5_r;

  // one Horner step per stage: s = c_i + round(s * x2 / 2^30)
  for (genvar j = 0; j < NSTEP; j++) begin : g_horner
    logic [35:0]          mag;
    logic [68:0]          prod;
    logic [35:0]          rnd;
    logic signed [SW-1:0] sum;

    always_comb begin
      mag  = hs_r[j][SW-1] ? 36'(-hs_r[j]) : 36'(hs_r[j]);
      prod = 69'(mag) * 69'(hx2_r[j]) + 69'd536870912;
      rnd  = prod[65:30];
      sum  = tsc_pkg::coef_signed(4'(TERM_COUNT - 2 - j))
             + (hs_r[j][SW-1] ? -$signed(rnd) : $signed(rnd));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv_r[j+1] <= 1'b0;
      end else if (advance) begin
        hv_r[j+1] <= hv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        hs_r[j+1]  <= sum;
        hx2_r[j+1] <= hx2_r[j];
        hx_r[j+1]  <= hx_r[j];
        hn_r[j+1]  <= hn_r[j];
      end
    end
  end

  // final scaling by x at Q.32, then saturate
  always_comb begin
    smag    = hs_r[NSTEP][SW-1] ? 36'(-hs_r[NSTEP]) : 36'(hs_r[NSTEP]);
    fprod   = 68'(smag) * 68'(hx_r[NSTEP]) + 68'd2147483648;
    sat_mag = (fmag_r > tsc_pkg::ONE_Q30) ? tsc_pkg::ONE_Q30 : fmag_r;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fmag_r      <= fprod[67:32];
      fsign_r     <= hs_r[NSTEP][SW-1] ^ hn_r[NSTEP];
      out_value_r <= fsign_r ? 32'(-sat_mag) : sat_mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      fv_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= rd_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      fv_r        <= hv_r[NSTEP];
      out_valid_r <= fv_r;
    end
  end

endmodule

[sv/taylor_sine_cosine_unit.sv]
// ----------------------------------------------------------------------------
// taylor_sine_cosine_unit
// Sine or cosine of a Q8.24 angle by a TERM_COUNT-term Taylor series,
// result in Q2.30 saturated to [-1, 1].
// ----------------------------------------------------------------------------
//
//  channel | ports          | payload
//  --------+----------------+-----------------------------------------------
//  input   | in_t*          | tdata: angle[31:0]; tuser: op (0 sine, 1 cos)
//  result  | out_t*         | tdata: value[31:0] signed Q2.30
//
//  One request per clock sustained while the result output is not stalled.
//  Accept to result: front register, queue write, queue read register,
//  five reduction/fold stages, TERM_COUNT-1 Horner multiply stages, scale and
//  output stages. The Horner multiplier per stage sets the pipeline length.
//  Reset clears only valid and pointer state. A stalled result output holds
//  the whole back pipeline; the queue keeps absorbing requests until full.
//
module taylor_sine_cosine_unit #(
  parameter int TERM_COUNT  = tsc_pkg::TERM_COUNT_DEF,
  parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] angle
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] value
);

  logic                 push, q_full, rd_en, rd_valid;
  tsc_pkg::front_item_t f_item, rd_item;

  // accept and classify the request
  tsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .angle    ($signed(in_tdata)),
    .push     (push),
    .q_full   (q_full),
    .item     (f_item)
  );

  // decouple front from back
  tsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_item  (f_item),
    .full     (q_full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_item  (rd_item)
  );

  // evaluate the series
  tsc_back #(.TERM_COUNT(TERM_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_item   (rd_item),
    .advance   (rd_en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata)
  );

endmodule

[tb/tb_taylor_sine_cosine_unit.sv]
// ----------------------------------------------------------------------------
// tb_taylor_sine_cosine_unit
// Self-checking bench for the Taylor sine/cosine unit: a bit-exact predictor
// computes each expected Q2.30 value as a request is accepted, and every
// result is compared in order while both stream sides idle and stall.
// ----------------------------------------------------------------------------
module tb_taylor_sine_cosine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: predicts the value of each accepted request and checks
  // results against the oldest prediction.
  class sine_scoreboard;
    logic [31:0] pending_values[$];
    int          error_count;

    // Inverse odd factorials at Q.32, rounded to nearest.
    function longint unsigned odd_fact_inv(int idx);
      case (idx)
        0:       return 64'd4294967296;
        1:       return 64'd715827883;
        2:       return 64'd35791394;
        3:       return 64'd852176;
        4:       return 64'd11836;
        5:       return 64'd108;
        6:       return 64'd1;
        default: return 64'd0;
      endcase
    endfunction

    // Signed times unsigned, rounded on the magnitude.
    function longint scaled_round(longint s, longint unsigned m, int sh);
      longint unsigned mag;
      longint unsigned p;
      mag = (s < 0) ? -s : s;
      p = (mag * m + (64'd1 << (sh - 1))) >> sh;
      return (s < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic [31:0] predict_value(tsc_pkg::op_t op, logic [31:0] angle);
      longint          arg;
      longint unsigned mag, k, prod, r, x, x2;
      longint          s;
      bit              neg;
      arg = longint'($signed(angle)) * 256;
      if (op == tsc_pkg::OP_COSINE) arg = longint'(tsc_pkg::HALF_PI_Q32) - arg;
      neg = arg < 0;
      mag = neg ? -arg : arg;
      // Reduce modulo 2*pi with the reciprocal, then correct.
      k = (mag * 64'(tsc_pkg::INV_TWO_PI_Q24)) >> 56;
      prod = k * 64'(tsc_pkg::TWO_PI_Q32);
      if (prod > mag) prod -= 64'(tsc_pkg::TWO_PI_Q32);
      r = mag - prod;
      if (r >= 64'(tsc_pkg::TWO_PI_Q32)) r -= 64'(tsc_pkg::TWO_PI_Q32);
      // Fold into the first quadrant.
      if (r > 64'(tsc_pkg::PI_Q32)) begin
        r -= 64'(tsc_pkg::PI_Q32);
        neg = !neg;
      end
      if (r > 64'(tsc_pkg::HALF_PI_Q32)) r = 64'(tsc_pkg::PI_Q32) - r;
      x = (r + 2) >> 2;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      // Horner over alternating odd terms.
      s = ((tsc_pkg::TERM_COUNT_DEF - 1) % 2)
          ? -longint'(odd_fact_inv(tsc_pkg::TERM_COUNT_DEF - 1))
          : longint'(odd_fact_inv(tsc_pkg::TERM_COUNT_DEF - 1));
      for (int i = tsc_pkg::TERM_COUNT_DEF - 2; i >= 0; i--)
        s = ((i % 2) ? -longint'(odd_fact_inv(i)) : longint'(odd_fact_inv(i)))
            + scaled_round(s, x2, 30);
      s = scaled_round(s, x, 32);
      if (neg) s = -s;
      if (s > longint'(tsc_pkg::ONE_Q30)) s = longint'(tsc_pkg::ONE_Q30);
      if (s < -longint'(tsc_pkg::ONE_Q30)) s = -longint'(tsc_pkg::ONE_Q30);
      return s[31:0];
    endfunction

    function void note_request(tsc_pkg::op_t op, logic [31:0] angle);
      pending_values.push_back(predict_value(op, angle));
    endfunction

    function void check_result(logic [31:0] value);
      logic [31:0] want;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result value=%0d", $time, $signed(value));
        error_count++;
        return;
      end
      want = pending_values.pop_front();
      if (value !== want) begin
        $display("%0t: value mismatch expected=%0d actual=%0d",
                 $time, $signed(want), $signed(value));
        error_count++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;
  localparam int PI_Q24      = 52707179;   // pi at Q8.24
  localparam int HALF_PI_Q24 = 26353589;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] angle
  logic        in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value

  sine_scoreboard sb;
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  taylor_sine_cosine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Stall the result side at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Note accepted requests, check accepted results, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(tsc_pkg::op_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (sb.pending_values.size() == 0 && !in_tvalid))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one request and hold it until accepted; maybe idle first.
  task automatic send_request(tsc_pkg::op_t op, logic [31:0] angle);
    if (in_tvalid && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end else if (!in_tvalid && $urandom_range(99) < sender_idle_pct) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly angles within a few turns, some full-range.
  task automatic send_random(int count);
    logic [31:0] angle;
    repeat (count) begin
      case ($urandom_range(3))
        0:       angle = $urandom;
        1:       angle = $urandom_range(4 * PI_Q24, 0) - 2 * PI_Q24;
        2:       angle = $urandom_range(32'hFFFF, 0) - 32'h8000;
        default: angle = $urandom_range(16 * PI_Q24, 0) - 8 * PI_Q24;
      endcase
      send_request(tsc_pkg::op_t'($urandom_range(1)), angle);
    end
  endtask

  initial begin
    logic [31:0] corners[$];
    sb = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    quiet_cycles       = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, field extremes, quadrant edges, near-one overshoot.
    corners = '{32'd0, 32'h7FFFFFFF, 32'h80000000, 32'd1, 32'hFFFFFFFF,
                HALF_PI_Q24, -HALF_PI_Q24, PI_Q24, -PI_Q24, 2 * PI_Q24,
                2 * PI_Q24 - 1, 3 * HALF_PI_Q24};
    foreach (corners[i]) begin
      send_request(tsc_pkg::OP_SINE, corners[i]);
      send_request(tsc_pkg::OP_COSINE, corners[i]);
    end

    // Random phases: free flow, slow sender, slow receiver, both slow.
    send_random(325);
    sender_idle_pct = 77;
    send_random(325);
    sender_idle_pct    = 0;
    receiver_stall_pct = 77;
    send_random(325);
    sender_idle_pct = 23;
    receiver_stall_pct = 23;
    send_random(325);
    in_tvalid <= 1'b0;

    // Drain, then allow for the pipeline latency.
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
